[rtl/fpd_pkg.sv]
// Package for the framed packet deframer: field widths, configuration
// register indexes, and the structs passed between front, queue and back.
// No dependencies.
package fpd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START = 8'd170;
    localparam logic [BYTE_W-1:0] RST_END   = 8'd85;
    localparam logic [LEN_W-1:0]  RST_MAX   = 6'd32;

    // Descriptor of one checked packet waiting to be drained.
    typedef struct packed {
        logic              bank;
        logic [BYTE_W-1:0] ptype;
        logic [LEN_W-1:0]  plen;
    } t_desc;

    // Payload buffer write port.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [LEN_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage

[rtl/fpd_rx_if.sv]
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on fpd_pkg.
interface fpd_rx_if import fpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/fpd_pkt_if.sv]
// Result channel: valid/ready handshake carrying one deframed payload beat.
// Depends on fpd_pkg.
interface fpd_pkt_if import fpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_type;
    logic [LEN_W-1:0]  packet_length;
    logic              has_data;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output packet_type, output packet_length,
                    output has_data, output data_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input packet_type, input packet_length,
                    input has_data, input data_byte, input byte_index,
                    input last, output ready);
endinterface

[rtl/framed_packet_deframer.sv]
// Framed packet deframer top level. Depends on fpd_pkg, fpd_rx_if, fpd_pkt_if,
// fpd_front, fpd_queue and fpd_back.
//
// The parser takes one received byte per cycle while the descriptor queue is
// not full (start, type, length, payload, XOR checksum, end) and stores the
// payload in one of two buffer banks. A packet whose end byte and checksum
// match is handed to the drain engine through a two-entry descriptor queue;
// bad or oversized frames vanish without a beat. The drain engine picks up a
// descriptor and then, for each beat, does the registered buffer read and
// then loads the output register, waiting while that register holds a beat
// not yet taken; a zero-length packet gives a single beat with has_data low.
// A descriptor leaves the queue only when its last beat is loaded, so byte
// intake stalls exactly while both banks hold packets whose last beat is not
// yet loaded. There is no reset sweep of the buffer.
module framed_packet_deframer import fpd_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fpd_rx_if.sink                i_rx,
    fpd_pkt_if.source             o_pkt
);

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    t_desc     push_desc;
    t_desc     head_desc;
    t_store_wr store_wr;

    fpd_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (push_desc),
        .o_wr        (store_wr)
    );

    fpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_desc)
    );

    fpd_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_q_empty (q_empty),
        .i_head    (head_desc),
        .o_pop     (q_pop),
        .o_pkt     (o_pkt)
    );

endmodule

[rtl/fpd_front.sv]
// Front end: configuration registers and frame parser. Writes payload into
// the current buffer bank and pushes a descriptor for each good packet.
// Depends on fpd_pkg and fpd_rx_if.
module fpd_front import fpd_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fpd_rx_if.sink                i_rx,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_desc                 o_desc,
    output t_store_wr             o_wr
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_END
    } t_phase;

    localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(BUF_DEPTH);

    t_phase            r_phase;
    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_end;
    logic [LEN_W-1:0]  r_max;
    logic [BYTE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] r_sum;
    logic              r_bank;

    logic              acc;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] max_b;
    logic [BYTE_W-1:0] limit;
    logic              good;

    assign i_rx.ready = !i_q_full;
    assign acc        = i_rx.valid && !i_q_full;
    assign b          = i_rx.rx_byte;
    assign max_b      = {{(BYTE_W-LEN_W){1'b0}}, r_max};
    assign limit      = (max_b > DEPTH_B) ? DEPTH_B : max_b;
    assign good       = (b == r_end) && (r_xor == r_sum);

    assign o_push       = acc && (r_phase == PH_END) && good;
    assign o_desc.bank  = r_bank;
    assign o_desc.ptype = r_type;
    assign o_desc.plen  = r_len;

    assign o_wr.en   = acc && (r_phase == PH_DATA);
    assign o_wr.bank = r_bank;
    assign o_wr.idx  = r_cnt;
    assign o_wr.data = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_start <= RST_START;
            r_end   <= RST_END;
            r_max   <= RST_MAX;
            r_type  <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START: r_start <= i_cfg_wdata;
                    CFG_END:   r_end   <= i_cfg_wdata;
                    CFG_MAX:   r_max   <= i_cfg_wdata[LEN_W-1:0];
                    default:   ;
                endcase
            end
            if (acc) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (b == r_start) r_phase <= PH_TYPE;
                    end
                    PH_TYPE: begin
                        r_type  <= b;
                        r_phase <= PH_LEN;
                    end
                    PH_LEN: begin
                        if (b > limit) begin
                            r_phase <= PH_HUNT;
                        end else begin
                            r_len   <= b[LEN_W-1:0];
                            r_cnt   <= '0;
                            r_xor   <= '0;
                            r_phase <= (b == '0) ? PH_SUM : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r_xor <= r_xor ^ b;
                        r_cnt <= r_cnt + LEN_W'(1);
                        if ((r_cnt + LEN_W'(1)) >= r_len) r_phase <= PH_SUM;
                    end
                    PH_SUM: begin
                        r_sum   <= b;
                        r_phase <= PH_END;
                    end
                    PH_END: begin
                        r_phase <= PH_HUNT;
                        if (good) r_bank <= !r_bank;
                    end
                    default: r_phase <= PH_HUNT;
                endcase
            end
        end
    end

endmodule

[rtl/fpd_queue.sv]
// Two-entry descriptor queue between the parser and the drain engine.
// Depends on fpd_pkg.
module fpd_queue import fpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc       r_ent [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

[rtl/fpd_back.sv]
// Back end: two-bank payload buffer and drain engine that turns each
// descriptor into result beats through an output register.
// Depends on fpd_pkg and fpd_pkt_if.
module fpd_back import fpd_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_store_wr i_wr,
    input  logic      i_q_empty,
    input  t_desc     i_head,
    output logic      o_pop,
    fpd_pkt_if.source o_pkt
);

    localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int MEM_DEPTH = 2 * (2 ** AW);

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_LOAD
    } t_bstate;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_bstate           r_state;
    t_desc             r_desc;
    logic [LEN_W-1:0]  r_k;

    logic              r_vld;
    logic [BYTE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic              r_has;
    logic [BYTE_W-1:0] r_data;
    logic [IDX_W-1:0]  r_idx;
    logic              r_last;

    logic              out_free;
    logic              zero_len;
    logic              is_last;

    assign out_free = !r_vld || o_pkt.ready;
    assign zero_len = (r_desc.plen == '0);
    assign is_last  = zero_len || ((r_k + LEN_W'(1)) == r_desc.plen);
    // hold the descriptor, and so its bank, until the last beat is loaded
    assign o_pop    = (r_state == B_LOAD) && out_free && is_last;

    assign o_pkt.valid         = r_vld;
    assign o_pkt.packet_type   = r_type;
    assign o_pkt.packet_length = r_len;
    assign o_pkt.has_data      = r_has;
    assign o_pkt.data_byte     = r_data;
    assign o_pkt.byte_index    = r_idx;
    assign o_pkt.last          = r_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[{i_wr.bank, i_wr.idx[AW-1:0]}] <= i_wr.data;
        r_rd_data <= r_mem[{r_desc.bank, r_k[AW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_vld   <= 1'b0;
            r_desc  <= '0;
            r_k     <= '0;
        end else begin
            if (r_vld && o_pkt.ready) r_vld <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_desc  <= i_head;
                        r_k     <= '0;
                        r_state <= B_FETCH;
                    end
                end
                B_FETCH: r_state <= B_LOAD;
                B_LOAD: begin
                    if (out_free) begin
                        r_vld  <= 1'b1;
                        r_type <= r_desc.ptype;
                        r_len  <= r_desc.plen;
                        r_has  <= !zero_len;
                        r_data <= zero_len ? '0 : r_rd_data;
                        r_idx  <= r_k[IDX_W-1:0];
                        r_last <= is_last;
                        if (is_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_k     <= r_k + LEN_W'(1);
                            r_state <= B_FETCH;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

[verif/framed_packet_deframer_tb.sv]
// Testbench for framed_packet_deframer: drives framed byte streams through the
// rx channel, predicts every payload beat and checks it on the pkt channel.
// Depends on fpd_pkg, fpd_rx_if, fpd_pkt_if and the deframer RTL.
`timescale 1ns / 100ps

module framed_packet_deframer_tb;
    import fpd_pkg::*;

    localparam int          BUF_DEPTH   = 32;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        PH_HUNT, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CHECKSUM, PH_TRAILER
    } t_frame_phase;

    typedef struct {
        logic [BYTE_W-1:0] ptype;
        logic [LEN_W-1:0]  plen;
        logic              has_data;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_pkt_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fpd_rx_if  rx_ch();
    fpd_pkt_if pkt_ch();

    framed_packet_deframer #(.BUF_DEPTH(BUF_DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_pkt       (pkt_ch)
    );

    // deframer shadow state
    logic [BYTE_W-1:0] cfg_start = RST_START;
    logic [BYTE_W-1:0] cfg_end   = RST_END;
    logic [LEN_W-1:0]  cfg_max   = RST_MAX;
    t_frame_phase      phase     = PH_HUNT;
    logic [BYTE_W-1:0] payload_mem [BUF_DEPTH];
    logic [LEN_W-1:0]  fill_count = '0;
    logic [BYTE_W-1:0] held_type  = '0;
    logic [LEN_W-1:0]  held_len   = '0;
    logic [BYTE_W-1:0] run_xor    = '0;
    logic [BYTE_W-1:0] rx_sum     = '0;

    t_pkt_beat   pending_beats[$];
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned framed_bytes = 0;
    bit          rx_steady    = 1'b0;
    bit          sink_steady  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned eff_limit();
        return (cfg_max > BUF_DEPTH) ? BUF_DEPTH : cfg_max;
    endfunction

    task automatic predict_rx(input logic [BYTE_W-1:0] b);
        t_pkt_beat beat;
        case (phase)
            PH_HUNT: begin
                if (b == cfg_start)
                    phase = PH_TYPE;
            end
            PH_TYPE: begin
                held_type = b;
                phase     = PH_LEN;
            end
            PH_LEN: begin
                if (b > eff_limit()) begin
                    phase = PH_HUNT;
                end else begin
                    held_len   = b[LEN_W-1:0];
                    fill_count = '0;
                    run_xor    = '0;
                    phase      = (b == 0) ? PH_CHECKSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (fill_count < BUF_DEPTH)
                    payload_mem[fill_count] = b;
                run_xor    = run_xor ^ b;
                fill_count = fill_count + 1'b1;
                if (fill_count >= held_len)
                    phase = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
                rx_sum = b;
                phase  = PH_TRAILER;
            end
            PH_TRAILER: begin
                phase = PH_HUNT;
                if (b == cfg_end && run_xor == rx_sum) begin
                    if (held_len == 0) begin
                        beat = '{held_type, '0, 1'b0, '0, '0, 1'b1};
                        pending_beats.push_back(beat);
                    end else begin
                        for (int k = 0; k < held_len && k < BUF_DEPTH; k++) begin
                            beat = '{held_type, held_len, 1'b1, payload_mem[k],
                                     k[IDX_W-1:0], (k + 1 == held_len)};
                            pending_beats.push_back(beat);
                        end
                    end
                end
            end
            default: phase = PH_HUNT;
        endcase
    endtask

    task automatic check_beat();
        t_pkt_beat want;
        if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("beat with nothing pending: type %0h data %0h",
                                      pkt_ch.packet_type, pkt_ch.data_byte));
            return;
        end
        want = pending_beats.pop_front();
        if (pkt_ch.packet_type !== want.ptype)
            report_mismatch($sformatf("packet_type got %0h want %0h",
                                      pkt_ch.packet_type, want.ptype));
        if (pkt_ch.packet_length !== want.plen)
            report_mismatch($sformatf("packet_length got %0d want %0d",
                                      pkt_ch.packet_length, want.plen));
        if (pkt_ch.has_data !== want.has_data)
            report_mismatch($sformatf("has_data got %0b want %0b",
                                      pkt_ch.has_data, want.has_data));
        if (pkt_ch.data_byte !== want.data)
            report_mismatch($sformatf("data_byte got %0h want %0h (index %0d)",
                                      pkt_ch.data_byte, want.data, want.idx));
        if (pkt_ch.byte_index !== want.idx)
            report_mismatch($sformatf("byte_index got %0d want %0d",
                                      pkt_ch.byte_index, want.idx));
        if (pkt_ch.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b (index %0d)",
                                      pkt_ch.last, want.last, want.idx));
    endtask

    initial begin : beat_sink
        int stall;
        pkt_ch.ready <= 1'b0;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                pkt_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pkt_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (i_rst_n !== 1'b1 || pkt_ch.valid !== 1'b1 || pkt_ch.ready !== 1'b1);
            check_beat();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = rx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk);
        while (rx_ch.ready !== 1'b1);
        predict_rx(b);
    endtask

    // fill < 0 draws random payload bytes
    task automatic send_frame(input logic [BYTE_W-1:0] ptype, input int len,
                              input int fill, input bit bad_sum, input bit bad_end);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] v;
        send_byte(cfg_start);
        send_byte(ptype);
        send_byte(len[BYTE_W-1:0]);
        if (len > eff_limit()) begin
            framed_bytes += 3;
            return;
        end
        sum = '0;
        for (int i = 0; i < len; i++) begin
            v = (fill < 0) ? BYTE_W'($urandom) : fill[BYTE_W-1:0];
            sum ^= v;
            send_byte(v);
        end
        send_byte(bad_sum ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
        send_byte(bad_end ? cfg_end ^ BYTE_W'($urandom_range(1, 255)) : cfg_end);
        framed_bytes += len + 5;
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] start_v,
                              input logic [BYTE_W-1:0] end_v,
                              input logic [LEN_W-1:0] max_v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_START;
        i_cfg_wdata <= start_v;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_END;
        i_cfg_wdata <= end_v;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAX;
        i_cfg_wdata <= CFG_DATA_W'(max_v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_start = start_v;
        cfg_end   = end_v;
        cfg_max   = max_v;
    endtask

    task automatic test_default_framing();
        send_frame(8'h00, 0, -1, 1'b0, 1'b0);
        send_frame(8'hFF, 1, 8'hFF, 1'b0, 1'b0);
        send_frame(8'h5A, 1, 8'h00, 1'b1, 1'b0);
        send_frame(8'hA5, 0, -1, 1'b0, 1'b1);
        send_frame(8'h33, 33, -1, 1'b0, 1'b0);
    endtask

    task automatic test_start_byte_in_payload();
        send_frame(cfg_start, 3, cfg_start, 1'b0, 1'b0);
        send_frame(cfg_end, 2, cfg_end, 1'b0, 1'b0);
        send_byte(8'h00);
        send_byte(cfg_end);
        send_frame(8'h12, 4, -1, 1'b0, 1'b0);
    endtask

    // back-to-back max frames fill both banks and stall intake
    task automatic test_full_buffers();
        rx_steady   = 1'b1;
        sink_steady = 1'b1;
        send_frame(8'h80, 32, -1, 1'b0, 1'b0);
        send_frame(8'h81, 32, -1, 1'b0, 1'b0);
        send_frame(8'h82, 32, -1, 1'b0, 1'b0);
        wait_drained();
        sink_steady = 1'b0;
        send_frame(8'h83, 32, 8'hFF, 1'b0, 1'b0);
        send_frame(8'h84, 0, -1, 1'b0, 1'b0);
        rx_steady = 1'b0;
        send_frame(8'h85, 32, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_config(8'h00, 8'hFF, 6'd0);
        send_frame(8'h01, 0, -1, 1'b0, 1'b0);
        send_frame(8'h02, 1, -1, 1'b0, 1'b0);
        send_frame(8'h03, 0, -1, 1'b0, 1'b1);
        set_config(8'hFF, 8'h00, 6'd1);
        send_frame(8'h04, 1, 8'hFF, 1'b0, 1'b0);
        send_frame(8'h05, 2, -1, 1'b0, 1'b0);
        send_frame(8'h06, 1, -1, 1'b0, 1'b0);
        // maximum beyond the buffer depth still clips at the buffer
        set_config(8'h3C, 8'h3C, 6'd63);
        send_frame(8'h07, 32, -1, 1'b0, 1'b0);
        send_frame(8'h08, 33, -1, 1'b0, 1'b0);
        send_frame(8'h09, 40, -1, 1'b0, 1'b0);
        send_frame(8'h0A, 5, 8'h3C, 1'b0, 1'b0);
        set_config(RST_START, RST_END, RST_MAX);
        send_frame(8'h0B, 2, -1, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned base;
        int unsigned pick;
        int unsigned lim;
        int          len;
        int          n;
        logic [BYTE_W-1:0] v;
        base = framed_bytes;
        while (framed_bytes - base < target) begin
            if ($urandom_range(0, 7) == 0) rx_steady   = ~rx_steady;
            if ($urandom_range(0, 7) == 0) sink_steady = ~sink_steady;
            pick = $urandom_range(0, 99);
            lim  = eff_limit();
            if (pick < 8) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    do v = BYTE_W'($urandom);
                    while (v == cfg_start);
                    send_byte(v);
                end
                framed_bytes += n;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(0, (lim < 8) ? lim : 8);
                    6, 7:             len = $urandom_range(0, lim);
                    8:                len = lim;
                    default:          len = ($urandom_range(0, 1) == 0) ?
                                            lim + $urandom_range(1, 3) : 255;
                endcase
                send_frame(BYTE_W'($urandom), len, -1,
                           (pick >= 85 && pick < 92), (pick >= 92));
            end
        end
    endtask

    initial begin
        int unsigned r;
        logic [LEN_W-1:0] max_v;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_START;
        i_cfg_wdata   <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_framing();
        test_start_byte_in_payload();
        test_full_buffers();
        test_register_extremes();
        repeat (3) begin
            r = $urandom_range(0, 3);
            max_v = (r == 0) ? LEN_W'($urandom_range(0, 4)) :
                    (r == 1) ? LEN_W'(32) : LEN_W'($urandom_range(0, 32));
            set_config(BYTE_W'($urandom), BYTE_W'($urandom), max_v);
            test_random_traffic(10);
        end

        rx_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
